// ===== rtl/core/deque_with_search_core_assert.svh =====
// Assertion macros shared by the deque-with-search RTL.
// Depends on nothing; clock, reset and property are passed in by the caller.
`ifndef DEQUE_WITH_SEARCH_CORE_ASSERT_SVH
`define DEQUE_WITH_SEARCH_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside of reset.
`define DQS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("deque_with_search_core: assertion failed");
// Check that a condition never holds outside of reset.
`define DQS_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("deque_with_search_core: forbidden condition seen");
`else
`define DQS_ASSERT(label, clk, rst, prop)
`define DQS_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== rtl/core/dqs_pkg.sv =====
// Shared types, constants and helpers for the deque-with-search core.
// Used by dqs_front, dqs_cmd_queue, dqs_back and deque_with_search_core.
`default_nettype none

package dqs_pkg;

  // Store geometry (DEPTH must be a power of two)
  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = ADDR_W + 1;

  // Transaction field widths
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int OCC_W    = 7;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Request kinds as they arrive on the input
  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INS_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SEARCH    = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_NORMAL = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;

  // Operations carried out by the back end
  typedef enum logic [1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_REMOVE    = 2'd2,
    OP_SEARCH    = 2'd3
  } op_t;

  // Classified command
  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Map an incoming request kind to a back-end operation
  function automatic op_t kind_to_op(input logic [KIND_W-1:0] kind);
    op_t op;
    case (kind)
      KIND_INS_FRONT: op = OP_INS_FRONT;
      KIND_INS_BACK:  op = OP_INS_BACK;
      KIND_REMOVE:    op = OP_REMOVE;
      KIND_SEARCH:    op = OP_SEARCH;
      default:        op = OP_SEARCH;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/deque_with_search_core.sv =====
// Top level of the deque-with-search core: front end, command queue, back end.
// Depends on dqs_pkg, dqs_front, dqs_cmd_queue and dqs_back.
//
//   Channel   Handshake         Fields
//   request   push / full       kind, value
//   result    pop / empty       ok, status, position, occupancy
//
// Inserts and removals are carried out directly from the idle state.
// A search reads one stored entry per cycle from the single read port of the entry store.
// Up to three requests wait in the front register and the command queue while
// the back end works or a result waits to be taken.
// Synchronous active-high reset empties the store; no clearing pass is needed.
`default_nettype none

module deque_with_search_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [dqs_pkg::KIND_W-1:0]         kind,
  input  logic signed [dqs_pkg::VALUE_W-1:0] value,
  output logic                               empty,
  input  logic                               pop,
  output logic                               ok,
  output logic [dqs_pkg::STATUS_W-1:0]       status,
  output logic [dqs_pkg::POS_W-1:0]          position,
  output logic [dqs_pkg::OCC_W-1:0]          occupancy
);
  import dqs_pkg::*;

  q_stat_t qs;
  logic    q_push;
  cmd_t    q_cmd;
  logic    cmd_pop;
  cmd_t    cmd;

  dqs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .kind   (kind),
    .value  (value),
    .qs     (qs),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  dqs_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_push),
    .wr_cmd (q_cmd),
    .rd_en  (cmd_pop),
    .rd_cmd (cmd),
    .qs     (qs)
  );

  dqs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .qs        (qs),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .ok        (ok),
    .status    (status),
    .position  (position),
    .occupancy (occupancy)
  );

endmodule

`default_nettype wire

// ===== rtl/core/dqs_front.sv =====
// Front end: accepts request transactions, classifies them into commands
// and hands them to the command queue. Depends on dqs_pkg.
`default_nettype none

module dqs_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [dqs_pkg::KIND_W-1:0]         kind,
  input  logic signed [dqs_pkg::VALUE_W-1:0] value,
  input  dqs_pkg::q_stat_t                   qs,
  output logic                               q_push,
  output dqs_pkg::cmd_t                      q_cmd
);
  import dqs_pkg::*;

  logic fe_valid;
  logic fe_valid_next;
  cmd_t fe_cmd;
  logic accept;

  // Hand the held command to the queue whenever it has room
  assign q_push = fe_valid && !qs.full;
  assign q_cmd  = fe_cmd;

  // Stall only when a command is held and cannot move on
  assign full   = fe_valid && qs.full;
  assign accept = push && !full;

  always_comb begin
    fe_valid_next = fe_valid;
    if (accept) begin
      fe_valid_next = 1'b1;
    end else if (q_push) begin
      fe_valid_next = 1'b0;
    end
  end

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      fe_valid <= 1'b0;
    end else begin
      fe_valid <= fe_valid_next;
    end
  end

  // Capture and classify the request
  always_ff @(posedge clk) begin
    if (accept) begin
      fe_cmd.op    <= kind_to_op(kind);
      fe_cmd.value <= value;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dqs_cmd_queue.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on dqs_pkg.
`default_nettype none

module dqs_cmd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  dqs_pkg::cmd_t    wr_cmd,
  input  logic             rd_en,
  output dqs_pkg::cmd_t    rd_cmd,
  output dqs_pkg::q_stat_t qs
);
  import dqs_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign qs.full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign qs.empty = (fill == '0);
  assign rd_cmd   = slots[rd_ptr];

  // Store an incoming command
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dqs_back.sv =====
// Back end: owns the circular entry store, executes commands and runs the
// one-entry-per-cycle search. Depends on dqs_pkg and the assertion header.
`default_nettype none

`include "deque_with_search_core_assert.svh"

module dqs_back (
  input  logic                                clk,
  input  logic                                rst,
  input  dqs_pkg::cmd_t                       cmd,
  input  dqs_pkg::q_stat_t                    qs,
  output logic                                cmd_pop,
  input  logic                                pop,
  output logic                                empty,
  output logic                                ok,
  output logic [dqs_pkg::STATUS_W-1:0]        status,
  output logic [dqs_pkg::POS_W-1:0]           position,
  output logic [dqs_pkg::OCC_W-1:0]           occupancy
);
  import dqs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_SEARCH = 2'b10
  } state_t;

  // Entry store
  logic signed [VALUE_W-1:0] mem [DEPTH];

  state_t                    state;
  state_t                    state_next;
  logic [ADDR_W-1:0]         front;
  logic [ADDR_W-1:0]         front_next;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;

  // Search pipeline
  logic signed [VALUE_W-1:0] key;
  logic [CNT_W-1:0]          issue_idx;
  logic                      rd_en;
  logic [ADDR_W-1:0]         rd_addr;
  logic signed [VALUE_W-1:0] rd_data;
  logic                      chk_valid;
  logic [ADDR_W-1:0]         chk_pos;
  logic                      match;
  logic                      search_start;

  // Store write
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;

  // Result register
  logic                      res_valid;
  logic                      res_free;
  logic                      produce;
  logic                      r_ok;
  logic [STATUS_W-1:0]       r_status;
  logic [POS_W-1:0]          r_pos;

  logic                      take;
  logic                      is_full;
  logic                      is_empty;

  assign res_free = !res_valid || pop;
  assign take     = (state == S_IDLE) && !qs.empty && res_free;
  assign cmd_pop  = take;
  assign is_full  = (count == CNT_W'(DEPTH));
  assign is_empty = (count == '0);

  assign rd_en   = (state == S_SEARCH) && (issue_idx < count);
  assign rd_addr = front + issue_idx[ADDR_W-1:0];
  assign match   = chk_valid && (rd_data == key);

  // Decode the command and step the search
  always_comb begin
    state_next   = state;
    front_next   = front;
    count_next   = count;
    wr_en        = 1'b0;
    wr_addr      = front;
    search_start = 1'b0;
    produce      = 1'b0;
    r_ok         = 1'b0;
    r_status     = STATUS_NORMAL;
    r_pos        = '0;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (cmd.op)
            OP_INS_FRONT: begin
              produce = 1'b1;
              if (is_full) begin
                r_status = STATUS_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = front - ADDR_W'(1);
                front_next = front - ADDR_W'(1);
                count_next = count + CNT_W'(1);
                r_ok       = 1'b1;
              end
            end
            OP_INS_BACK: begin
              produce = 1'b1;
              if (is_full) begin
                r_status = STATUS_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = front + count[ADDR_W-1:0];
                count_next = count + CNT_W'(1);
                r_ok       = 1'b1;
              end
            end
            OP_REMOVE: begin
              produce = 1'b1;
              if (is_empty) begin
                r_status = STATUS_EMPTY;
              end else begin
                front_next = front + ADDR_W'(1);
                count_next = count - CNT_W'(1);
                r_ok       = 1'b1;
              end
            end
            OP_SEARCH: begin
              if (is_empty) begin
                produce = 1'b1;
              end else begin
                search_start = 1'b1;
                state_next   = S_SEARCH;
              end
            end
            default: begin
              produce = 1'b0;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (match) begin
          produce    = 1'b1;
          r_ok       = 1'b1;
          r_pos      = POS_W'(chk_pos);
          state_next = S_IDLE;
        end else if (!rd_en && !chk_valid) begin
          produce    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      chk_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      count     <= count_next;
      chk_valid <= rd_en && !match;
      if (produce) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Search key and read cursor
  always_ff @(posedge clk) begin
    if (search_start) begin
      key       <= cmd.value;
      issue_idx <= '0;
    end else if (rd_en) begin
      issue_idx <= issue_idx + CNT_W'(1);
    end
    if (rd_en) begin
      chk_pos <= issue_idx[ADDR_W-1:0];
    end
  end

  // Entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Hold the finished result until it is taken
  always_ff @(posedge clk) begin
    if (produce) begin
      ok        <= r_ok;
      status    <= r_status;
      position  <= r_pos;
      occupancy <= OCC_W'(count_next);
    end
  end

  assign empty = !res_valid;

  `DQS_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `DQS_ASSERT_NEVER(a_no_overwrite, clk, rst, res_valid && !pop && produce)
  `DQS_ASSERT(a_search_holds, clk, rst, (state == S_SEARCH) |=> $stable(count) && $stable(front))
  `DQS_ASSERT(a_check_in_window, clk, rst, chk_valid |-> ({1'b0, chk_pos} < count))

endmodule

`default_nettype wire
